/* hdl/rldp_pkg.sv */
// rldp_pkg: shared types and constants for the run-length density plane decoder
// status and phase codes, configuration register map, reciprocal constants
// no dependencies
package rldp_pkg;

  localparam int CodeWidth   = 8;
  localparam int PosWidth    = 24;
  localparam int DensWidth   = 32;
  localparam int StatusWidth = 3;

  localparam logic [CodeWidth-1:0] ESCAPE_CODE = 8'hFF;

  // status codes
  localparam logic [StatusWidth-1:0] ST_BUSY     = 3'd0;
  localparam logic [StatusWidth-1:0] ST_OK       = 3'd1;
  localparam logic [StatusWidth-1:0] ST_TRUNC    = 3'd2;
  localparam logic [StatusWidth-1:0] ST_ZERO     = 3'd3;
  localparam logic [StatusWidth-1:0] ST_OVERRUN  = 3'd4;
  localparam logic [StatusWidth-1:0] ST_MISMATCH = 3'd5;

  // decoder phase codes
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FULL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_WINDOW_OFFSET = 2'd1;
  localparam logic [1:0] CFG_WINDOW_COUNT  = 2'd2;
  localparam logic [1:0] CFG_MAX_DENSITY   = 2'd3;

  // floor(n / 127) = (n * RECIP_BIG) >> RECIP_BIG_SHIFT for n < 2**31
  localparam logic [31:0] RECIP_BIG       = 32'd2164392969;
  localparam int          RECIP_BIG_SHIFT = 38;
  // floor(n / 127) = (n * RECIP_SMALL) >> RECIP_SMALL_SHIFT for n < 2**15
  localparam logic [15:0] RECIP_SMALL       = 16'd33027;
  localparam int          RECIP_SMALL_SHIFT = 22;
  localparam logic [7:0]  HALF_DIVISOR      = 8'd127;

  typedef struct packed {
    logic [PosWidth-1:0]  full_count;
    logic [PosWidth-1:0]  window_offset;
    logic [PosWidth-1:0]  window_count;
    logic [DensWidth-1:0] max_density;
  } cfg_t;

  typedef struct packed {
    logic                   has_run;
    logic [PosWidth-1:0]    run_start;
    logic [CodeWidth-1:0]   run_length;
    logic [StatusWidth-1:0] status;
  } rep_t;

  typedef struct packed {
    rep_t                 rep;
    logic [CodeWidth-1:0] value;
  } run_t;

endpackage

/* hdl/rle_density_plane_decoder.sv */
// rle_density_plane_decoder: run-length frame decoder with plane window clipping
// pipeline: input register s0, decoder into s1, then s2 and the output register
// throughput: one input word per cycle unless out_ready stalls the pipeline
// reset: rst (synchronous) clears frame state and pipeline valids and loads the
// register defaults; the density scale follows max_density through its registers
module rle_density_plane_decoder import rldp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CodeWidth-1:0]   code_byte,
  input  logic                   frame_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   has_run,
  output logic [PosWidth-1:0]    run_start,
  output logic [CodeWidth-1:0]   run_length,
  output logic [DensWidth-1:0]   density,
  output logic [StatusWidth-1:0] status,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [DensWidth-1:0]   cfg_data
);

  cfg_t cfg;

  logic                 s0_valid;
  logic [CodeWidth-1:0] s0_code;
  logic                 s0_last;
  logic                 s1_valid;
  run_t                 s1_run;
  logic                 s2_valid;
  rep_t                 s2_rep;
  rep_t                 out_rep;

  logic out_free, s2_free, s1_free, s0_free, step;
  run_t dec_run;
  logic dec_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_count    <= 24'd1;
      cfg.window_offset <= '0;
      cfg.window_count  <= 24'd1;
      cfg.max_density   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FULL_COUNT:    cfg.full_count    <= cfg_data[PosWidth-1:0];
        CFG_WINDOW_OFFSET: cfg.window_offset <= cfg_data[PosWidth-1:0];
        CFG_WINDOW_COUNT:  cfg.window_count  <= cfg_data[PosWidth-1:0];
        CFG_MAX_DENSITY:   cfg.max_density   <= cfg_data;
        default: ;
      endcase
    end
  end

  // each stage advances when the stage after it is empty or moving
  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s0_free  = !s0_valid || s1_free;
  assign step     = s0_valid && s1_free;
  assign in_ready = s0_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_free) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      s0_code <= code_byte;
      s0_last <= frame_end;
    end
  end

  rldp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .code_byte (s0_code),
    .frame_end (s0_last),
    .cfg       (cfg),
    .run       (dec_run),
    .emit      (dec_emit)
  );

  // words that produce no result drop out here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= step && dec_emit;
      if (s2_free) s2_valid <= s1_valid;
      if (out_free) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) s1_run <= dec_run;
    if (s2_free) s2_rep <= s1_run.rep;
    if (out_free) out_rep <= s2_rep;
  end

  rldp_scale u_scale (
    .clk         (clk),
    .max_density (cfg.max_density),
    .load_mul    (s2_free),
    .value       (s1_run.rep.has_run ? s1_run.value : '0),
    .load_out    (out_free),
    .density     (density)
  );

  assign has_run    = out_rep.has_run;
  assign run_start  = out_rep.run_start;
  assign run_length = out_rep.run_length;
  assign status     = out_rep.status;

endmodule

/* hdl/rldp_decode.sv */
// rldp_decode: escape-marker byte decoder with frame position and window clipping
// holds the per-frame state; produces at most one run report per consumed byte
// depends on rldp_pkg
module rldp_decode import rldp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [CodeWidth-1:0] code_byte,
  input  logic                 frame_end,
  input  cfg_t                 cfg,
  output run_t                 run,
  output logic                 emit
);

  logic [1:0]           phase, phase_next;
  logic [CodeWidth-1:0] held_value, held_value_next;
  logic [PosWidth:0]    out_position, out_position_next;
  logic                 error_seen, error_seen_next;

  logic [CodeWidth-1:0] value, repeats;
  logic [PosWidth:0]    end_pos, win_end, win_lo, lo, hi, start_full, len_full;
  logic                 overlap, overrun, is_run, is_fail;
  logic [StatusWidth-1:0] fail_code;

  always_comb begin
    value      = (phase == PH_COUNT) ? held_value : code_byte;
    repeats    = (phase == PH_COUNT) ? code_byte : 8'd1;
    end_pos    = out_position + {{(PosWidth+1-CodeWidth){1'b0}}, repeats};
    win_lo     = {1'b0, cfg.window_offset};
    win_end    = win_lo + {1'b0, cfg.window_count};
    lo         = (out_position > win_lo) ? out_position : win_lo;
    hi         = (end_pos < win_end) ? end_pos : win_end;
    overlap    = lo < hi;
    overrun    = end_pos > {1'b0, cfg.full_count};
    start_full = lo - win_lo;
    len_full   = hi - lo;
  end

  always_comb begin
    phase_next        = phase;
    held_value_next   = held_value;
    out_position_next = out_position;
    error_seen_next   = error_seen;
    run               = '0;
    emit              = 1'b0;
    is_run            = 1'b0;
    is_fail           = 1'b0;
    fail_code         = ST_BUSY;

    if (error_seen) begin
      // dropping until the frame ends
      if (frame_end) begin
        phase_next        = PH_LEAD;
        held_value_next   = '0;
        out_position_next = '0;
        error_seen_next   = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_VALUE: begin
          if (frame_end) begin
            is_fail   = 1'b1;
            fail_code = ST_TRUNC;
          end else begin
            held_value_next = code_byte;
            phase_next      = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (code_byte == '0) begin
            is_fail   = 1'b1;
            fail_code = ST_ZERO;
          end else begin
            is_run = 1'b1;
          end
        end
        default: begin
          if (code_byte == ESCAPE_CODE) begin
            if (frame_end) begin
              is_fail   = 1'b1;
              fail_code = ST_TRUNC;
            end else begin
              phase_next = PH_VALUE;
            end
          end else begin
            is_run = 1'b1;
          end
        end
      endcase

      if (is_run && overrun) begin
        is_run    = 1'b0;
        is_fail   = 1'b1;
        fail_code = ST_OVERRUN;
      end

      if (is_fail) begin
        emit           = 1'b1;
        run.rep.status = fail_code;
        if (frame_end) begin
          phase_next        = PH_LEAD;
          held_value_next   = '0;
          out_position_next = '0;
          error_seen_next   = 1'b0;
        end else begin
          error_seen_next = 1'b1;
          phase_next      = PH_LEAD;
        end
      end else if (is_run) begin
        out_position_next = end_pos;
        phase_next        = PH_LEAD;
        if (overlap) begin
          run.rep.has_run    = 1'b1;
          run.rep.run_start  = start_full[PosWidth-1:0];
          run.rep.run_length = len_full[CodeWidth-1:0];
          run.value          = value;
        end
        if (frame_end) begin
          run.rep.status    = (end_pos == {1'b0, cfg.full_count}) ? ST_OK : ST_MISMATCH;
          phase_next        = PH_LEAD;
          held_value_next   = '0;
          out_position_next = '0;
          error_seen_next   = 1'b0;
        end
        emit = overlap | frame_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      held_value   <= '0;
      out_position <= '0;
      error_seen   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      held_value   <= held_value_next;
      out_position <= out_position_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

/* hdl/rldp_scale.sv */
// rldp_scale: density scaling round(value * max_density / 254), saturating
// max_density is split into quotient and remainder by 254, then two short stages
// depends on rldp_pkg
module rldp_scale import rldp_pkg::*; (
  input  logic                 clk,
  input  logic [DensWidth-1:0] max_density,
  input  logic                 load_mul,
  input  logic [CodeWidth-1:0] value,
  input  logic                 load_out,
  output logic [DensWidth-1:0] density
);

  // max_density = 254 * max_quot + max_rem, refreshed continuously
  logic [62:0]          quot_prod;
  logic [24:0]          max_quot;
  logic [7:0]           max_rem;
  logic [32:0]          quot_x254;
  logic [DensWidth:0]   rem_diff;

  logic [32:0]          prod_hi;
  logic [15:0]          frac;
  logic [30:0]          frac_prod;
  logic [7:0]           frac_quot;
  logic [33:0]          dens_sum;

  always_comb begin
    quot_prod = {1'b0, max_density[DensWidth-1:1]} * {31'd0, RECIP_BIG};
    quot_x254 = {max_quot, 8'd0} - {7'd0, max_quot, 1'b0};
    rem_diff  = {1'b0, max_density} - quot_x254;
  end

  always_ff @(posedge clk) begin
    max_quot <= quot_prod[RECIP_BIG_SHIFT +: 25];
    max_rem  <= rem_diff[7:0];
  end

  // value * max = 254 * value * quot + value * rem
  always_ff @(posedge clk) begin
    if (load_mul) begin
      prod_hi <= {25'd0, value} * {8'd0, max_quot};
      frac    <= {8'd0, value} * {8'd0, max_rem} + {8'd0, HALF_DIVISOR};
    end
  end

  always_comb begin
    frac_prod = {16'd0, frac[15:1]} * {15'd0, RECIP_SMALL};
    frac_quot = frac_prod[RECIP_SMALL_SHIFT +: 8];
    dens_sum  = {1'b0, prod_hi} + {26'd0, frac_quot};
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      density <= (dens_sum[33:32] != 2'd0) ? {DensWidth{1'b1}} : dens_sum[DensWidth-1:0];
    end
  end

endmodule
